/* src/thsc_pkg.sv */
package thsc_pkg;

    localparam int unsigned SCRATCH_BYTES = 9;
    localparam int unsigned POS_W         = 4;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(SCRATCH_BYTES - 1);

    // scratchpad byte slots
    localparam logic [POS_W-1:0] POS_TEMP_LSB = 4'd0;
    localparam logic [POS_W-1:0] POS_TEMP_MSB = 4'd1;
    localparam logic [POS_W-1:0] POS_ALARM_HI = 4'd2;
    localparam logic [POS_W-1:0] POS_ALARM_LO = 4'd3;
    localparam logic [POS_W-1:0] POS_CONFIG   = 4'd4;

    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
    localparam logic [3:0] RES_BASE      = 4'd9;
    localparam int unsigned RES_LSB      = 5;

    localparam int unsigned TEMP_W   = 13;
    localparam int unsigned OUT_DW   = 40;

    typedef logic [7:0]        t_byte;
    typedef logic [POS_W-1:0]  t_pos;

    // one byte of the reflected 1-Wire CRC-8, LSB first
    function automatic t_byte crc8_byte(input t_byte crc, input t_byte data);
        t_byte v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY_REFL;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage

/* src/thermometer_scratchpad_checker_unit.sv */
// Thermometer scratchpad checker. Feed the nine scratchpad bytes in order, one
// item per byte; tuser set on a byte marks it as byte 0 and drops any partial
// frame. On the ninth byte one result item comes out with the temperature in
// signed sixteenths of a degree, both alarm bytes, the resolution (9 to 12) and
// a CRC-ok flag; the result is sent whether or not the CRC passes. One byte is
// taken every cycle unless a waiting result is stalled: the CRC step and the capture sit between the input
// handshake and a single output register, and a new byte is accepted while a
// result is still waiting as long as the output side takes it in that cycle.
module thermometer_scratchpad_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] frame_start
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [12:0] temperature_sixteenths, [20:13] high_alarm,
                                     // [28:21] low_alarm, [32:29] resolution_bits, [39:33] 0
    output logic        o_m_tuser    // [0] crc_ok
);
    import thsc_pkg::*;

    t_pos  r_pos,      n_pos;
    t_byte r_crc,      n_crc;
    t_byte r_temp_lo,  n_temp_lo;
    t_byte r_temp_hi,  n_temp_hi;
    t_byte r_alarm_hi, n_alarm_hi;
    t_byte r_alarm_lo, n_alarm_lo;
    t_byte r_cfg,      n_cfg;

    logic              r_out_valid, n_out_valid;
    logic [TEMP_W-1:0] r_out_temp;
    t_byte             r_out_ahi, r_out_alo;
    logic [3:0]        r_out_res;
    logic              r_out_crc_ok;

    logic  in_acc;
    logic  out_acc;
    t_pos  cur_pos;
    t_byte cur_crc;
    t_byte crc_next;
    logic  frame_done;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_acc    = r_out_valid && i_m_tready;

    assign cur_pos    = i_s_tuser ? '0 : r_pos;
    assign cur_crc    = i_s_tuser ? '0 : r_crc;
    assign crc_next   = crc8_byte(cur_crc, i_s_tdata);
    assign frame_done = in_acc && (cur_pos >= LAST_POS);

    always_comb begin
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_temp_lo  = r_temp_lo;
        n_temp_hi  = r_temp_hi;
        n_alarm_hi = r_alarm_hi;
        n_alarm_lo = r_alarm_lo;
        n_cfg      = r_cfg;
        if (in_acc) begin
            case (cur_pos)
                POS_TEMP_LSB: n_temp_lo  = i_s_tdata;
                POS_TEMP_MSB: n_temp_hi  = i_s_tdata;
                POS_ALARM_HI: n_alarm_hi = i_s_tdata;
                POS_ALARM_LO: n_alarm_lo = i_s_tdata;
                POS_CONFIG:   n_cfg      = i_s_tdata;
                default:      ;
            endcase
            if (frame_done) begin
                n_pos = '0;
                n_crc = '0;
            end else begin
                n_pos = cur_pos + 1'b1;
                n_crc = crc_next;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_acc) begin
            n_out_valid = 1'b0;
        end
        if (frame_done) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_crc       <= '0;
            r_temp_lo   <= '0;
            r_temp_hi   <= '0;
            r_alarm_hi  <= '0;
            r_alarm_lo  <= '0;
            r_cfg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_temp_lo   <= n_temp_lo;
            r_temp_hi   <= n_temp_hi;
            r_alarm_hi  <= n_alarm_hi;
            r_alarm_lo  <= n_alarm_lo;
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    // bytes 0..4 are never written on the last byte, so the stored copies are current
    always_ff @(posedge i_clk) begin
        if (frame_done) begin
            r_out_temp   <= {r_temp_hi[TEMP_W-9:0], r_temp_lo};
            r_out_ahi    <= r_alarm_hi;
            r_out_alo    <= r_alarm_lo;
            r_out_res    <= RES_BASE + {2'b00, r_cfg[RES_LSB+1:RES_LSB]};
            r_out_crc_ok <= (crc_next == 8'h00);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_res, r_out_alo, r_out_ahi, r_out_temp};
    assign o_m_tuser  = r_out_crc_ok;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS)
        else $error("byte position beyond last scratchpad byte");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_tuser) |=> (r_pos == POS_TEMP_MSB))
        else $error("frame start did not restart at byte 0");

    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_s_tuser && r_pos == LAST_POS)
            |=> (o_m_tvalid && r_pos == '0 && r_crc == '0))
        else $error("last byte did not produce a result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(in_acc))
        else $error("result appeared without an input byte");

endmodule
